// File: sv/lobm_pkg.sv
// Shared types and codes of the limit order book matcher.
package lobm_pkg;

    typedef enum logic [1:0] {
        MODE_BUY  = 2'd0,
        MODE_SELL = 2'd1
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TRADE     = 3'd0,
        KIND_RESTED    = 3'd1,
        KIND_FILLED    = 3'd2,
        KIND_CANCELLED = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_REJECTED  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        BOOK_NOP  = 3'd0,
        BOOK_INS  = 3'd1,
        BOOK_DEL  = 3'd2,
        BOOK_POP  = 3'd3,
        BOOK_SETQ = 3'd4
    } book_op_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_CANCEL = 2'd1,
        S_MATCH  = 2'd2,
        S_FINISH = 2'd3
    } state_t;

    typedef struct packed {
        logic hit;
        logic full;
        logic empty;
    } book_stat_t;

    localparam int unsigned ID_BITS = 32;

endpackage

// File: sv/limit_order_book_matcher_unit.sv
// Price-time priority order book matcher: sequencer, output register and both book sides.
//
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall  | mode, order_id, limit_price, quantity
//  out     | out       | out_valid/out_stall| kind, buyer_id, seller_id, trade_qty,
//          |           |                    |   trade_price, last
//
// A cancel is accepted, then searches both sides at once in S_CANCEL.
// A buy or sell is accepted, then S_MATCH makes the fills; each fill pops or
// trims the opposite head cell, and S_FINISH rests any remainder, or rejects it if full.
// Reset clears the fill counts of both sides; cell contents are left as they are.
// A stalled output register holds the sequencer until its record is taken.
module limit_order_book_matcher_unit #(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [31:0]           order_id,
    input  logic [PRICE_BITS-1:0] limit_price,
    input  logic [QTY_BITS-1:0]   quantity,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            kind,
    output logic [31:0]           buyer_id,
    output logic [31:0]           seller_id,
    output logic [QTY_BITS-1:0]   trade_qty,
    output logic [PRICE_BITS-1:0] trade_price,
    output logic                  last
);
    import lobm_pkg::*;

    state_t                state_reg, state_next;
    logic                  buy_reg;
    logic [31:0]           id_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 kind_reg, kind_next;
    logic [31:0]           buyer_reg, buyer_next;
    logic [31:0]           seller_reg, seller_next;
    logic [QTY_BITS-1:0]   tqty_reg, tqty_next;
    logic [PRICE_BITS-1:0] tprice_reg, tprice_next;
    logic                  last_reg, last_next;

    book_op_t              bid_op, ask_op;
    logic [QTY_BITS-1:0]   bid_wqty, ask_wqty;
    logic [31:0]           bid_hid, ask_hid, opp_id;
    logic [PRICE_BITS-1:0] bid_hprice, ask_hprice, opp_price;
    logic [QTY_BITS-1:0]   bid_hqty, ask_hqty, opp_qty;
    book_stat_t            bid_stat, ask_stat, opp_stat, own_stat;

    logic                  accept, can_emit, price_cross;
    logic [QTY_BITS-1:0]   traded;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign can_emit = !out_valid_reg || !out_stall;

    assign opp_id    = buy_reg ? ask_hid    : bid_hid;
    assign opp_price = buy_reg ? ask_hprice : bid_hprice;
    assign opp_qty   = buy_reg ? ask_hqty   : bid_hqty;
    assign opp_stat  = buy_reg ? ask_stat   : bid_stat;
    assign own_stat  = buy_reg ? bid_stat   : ask_stat;
    assign price_cross = buy_reg ? (opp_price <= price_reg) : (opp_price >= price_reg);
    assign traded    = (qty_reg < opp_qty) ? qty_reg : opp_qty;

    always_comb
    begin
        state_next     = state_reg;
        qty_next       = qty_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        buyer_next     = buyer_reg;
        seller_next    = seller_reg;
        tqty_next      = tqty_reg;
        tprice_next    = tprice_reg;
        last_next      = last_reg;
        bid_op         = BOOK_NOP;
        ask_op         = BOOK_NOP;
        bid_wqty       = qty_reg;
        ask_wqty       = qty_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qty_next = quantity;
                    if (mode == MODE_BUY || mode == MODE_SELL)
                        state_next = S_MATCH;
                    else
                        state_next = S_CANCEL;
                end
            end
            S_CANCEL:
            begin
                if (can_emit)
                begin
                    bid_op = BOOK_DEL;
                    ask_op = bid_stat.hit ? BOOK_NOP : BOOK_DEL;
                    out_valid_next = 1'b1;
                    kind_next   = (bid_stat.hit || ask_stat.hit) ? KIND_CANCELLED
                                                                 : KIND_NOT_FOUND;
                    buyer_next  = id_reg;
                    seller_next = '0;
                    tqty_next   = '0;
                    tprice_next = '0;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MATCH:
            begin
                if (qty_reg == '0 || opp_stat.empty || !price_cross)
                    state_next = S_FINISH;
                else if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    kind_next   = KIND_TRADE;
                    buyer_next  = buy_reg ? id_reg : opp_id;
                    seller_next = buy_reg ? opp_id : id_reg;
                    tqty_next   = traded;
                    tprice_next = opp_price;
                    last_next   = 1'b0;
                    qty_next    = qty_reg - traded;
                    // Drop the resting order when it is used up, else trim it.
                    if (buy_reg)
                    begin
                        ask_op   = (opp_qty == traded) ? BOOK_POP : BOOK_SETQ;
                        ask_wqty = opp_qty - traded;
                    end
                    else
                    begin
                        bid_op   = (opp_qty == traded) ? BOOK_POP : BOOK_SETQ;
                        bid_wqty = opp_qty - traded;
                    end
                end
            end
            S_FINISH:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    buyer_next  = id_reg;
                    seller_next = '0;
                    tprice_next = '0;
                    last_next   = 1'b1;
                    tqty_next   = qty_reg;
                    if (qty_reg == '0)
                        kind_next = KIND_FILLED;
                    else if (own_stat.full)
                        kind_next = KIND_REJECTED;
                    else
                    begin
                        kind_next = KIND_RESTED;
                        if (buy_reg)
                            bid_op = BOOK_INS;
                        else
                            ask_op = BOOK_INS;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buy_reg   <= (mode == MODE_BUY);
            id_reg    <= order_id;
            price_reg <= limit_price;
        end
        qty_reg    <= qty_next;
        kind_reg   <= kind_next;
        buyer_reg  <= buyer_next;
        seller_reg <= seller_next;
        tqty_reg   <= tqty_next;
        tprice_reg <= tprice_next;
        last_reg   <= last_next;
    end

    lobm_book #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .IS_BID     (1'b1)
    ) u_bids (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (bid_op),
        .new_id     (id_reg),
        .new_price  (price_reg),
        .new_qty    (bid_wqty),
        .head_id    (bid_hid),
        .head_price (bid_hprice),
        .head_qty   (bid_hqty),
        .stat       (bid_stat)
    );

    lobm_book #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS),
        .IS_BID     (1'b0)
    ) u_asks (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (ask_op),
        .new_id     (id_reg),
        .new_price  (price_reg),
        .new_qty    (ask_wqty),
        .head_id    (ask_hid),
        .head_price (ask_hprice),
        .head_qty   (ask_hqty),
        .stat       (ask_stat)
    );

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign buyer_id    = buyer_reg;
    assign seller_id   = seller_reg;
    assign trade_qty   = tqty_reg;
    assign trade_price = tprice_reg;
    assign last        = last_reg;

    a_trade_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_TRADE) |-> !last)
        else $error("trade record marked last");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind != KIND_TRADE) |-> last)
        else $error("status record not marked last");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("sequencer idle after a transaction was taken");

    a_one_side_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH || state_reg == S_FINISH) |->
            (bid_op == BOOK_NOP || ask_op == BOOK_NOP))
        else $error("both sides changed by one order step");

endmodule

// File: sv/lobm_cell.sv
// One book cell: holds one resting order and trades data with its neighbours.
module lobm_cell #(
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16,
    parameter bit IS_BID     = 1'b1,
    parameter bit IS_HEAD    = 1'b0
) (
    input  logic                     clk,
    input  lobm_pkg::book_op_t       op,
    input  logic                     valid,
    input  logic                     worse_in,
    input  logic                     hit_in,
    input  logic [31:0]              new_id,
    input  logic [PRICE_BITS-1:0]    new_price,
    input  logic [QTY_BITS-1:0]      new_qty,
    input  logic [31:0]              left_id,
    input  logic [PRICE_BITS-1:0]    left_price,
    input  logic [QTY_BITS-1:0]      left_qty,
    input  logic [31:0]              right_id,
    input  logic [PRICE_BITS-1:0]    right_price,
    input  logic [QTY_BITS-1:0]      right_qty,
    output logic [31:0]              id,
    output logic [PRICE_BITS-1:0]    price,
    output logic [QTY_BITS-1:0]      qty,
    output logic                     worse_out,
    output logic                     hit_out
);
    import lobm_pkg::*;

    logic [31:0]           id_reg, id_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [QTY_BITS-1:0]   qty_reg, qty_next;
    logic                  beaten;

    // A cell is behind the insertion point once it is empty or strictly worse.
    assign beaten    = IS_BID ? (price_reg < new_price) : (price_reg > new_price);
    assign worse_out = !valid || beaten;
    assign hit_out   = hit_in || (valid && (id_reg == new_id));

    always_comb
    begin
        id_next    = id_reg;
        price_next = price_reg;
        qty_next   = qty_reg;
        unique case (op)
            BOOK_INS:
            begin
                if (worse_in)
                begin
                    id_next    = left_id;
                    price_next = left_price;
                    qty_next   = left_qty;
                end
                else if (worse_out)
                begin
                    id_next    = new_id;
                    price_next = new_price;
                    qty_next   = new_qty;
                end
            end
            BOOK_DEL:
            begin
                if (hit_out)
                begin
                    id_next    = right_id;
                    price_next = right_price;
                    qty_next   = right_qty;
                end
            end
            BOOK_POP:
            begin
                id_next    = right_id;
                price_next = right_price;
                qty_next   = right_qty;
            end
            BOOK_SETQ:
            begin
                if (IS_HEAD)
                    qty_next = new_qty;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
    end

    assign id    = id_reg;
    assign price = price_reg;
    assign qty   = qty_reg;

endmodule

// File: sv/lobm_book.sv
// One side of the book: a row of cells, best order at the head, and a fill count.
module lobm_book #(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16,
    parameter bit IS_BID     = 1'b1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lobm_pkg::book_op_t       op,
    input  logic [31:0]              new_id,
    input  logic [PRICE_BITS-1:0]    new_price,
    input  logic [QTY_BITS-1:0]      new_qty,
    output logic [31:0]              head_id,
    output logic [PRICE_BITS-1:0]    head_price,
    output logic [QTY_BITS-1:0]      head_qty,
    output lobm_pkg::book_stat_t     stat
);
    import lobm_pkg::*;

    localparam int CW = $clog2(BOOK_DEPTH + 1);

    logic [CW-1:0]         count_reg, count_next;
    logic [31:0]           id_q    [BOOK_DEPTH];
    logic [PRICE_BITS-1:0] price_q [BOOK_DEPTH];
    logic [QTY_BITS-1:0]   qty_q   [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] valid;
    logic [BOOK_DEPTH-1:0] worse;
    logic [BOOK_DEPTH-1:0] hit;

    for (genvar i = 0; i < BOOK_DEPTH; i++)
    begin : g_cell
        localparam int L = (i == 0) ? 0 : i - 1;
        localparam int R = (i == BOOK_DEPTH - 1) ? i : i + 1;
        logic worse_in, hit_in;

        assign valid[i] = count_reg > CW'(i);
        assign worse_in = (i == 0) ? 1'b0 : worse[L];
        assign hit_in   = (i == 0) ? 1'b0 : hit[L];

        lobm_cell #(
            .PRICE_BITS (PRICE_BITS),
            .QTY_BITS   (QTY_BITS),
            .IS_BID     (IS_BID),
            .IS_HEAD    (i == 0)
        ) u_cell (
            .clk         (clk),
            .op          (op),
            .valid       (valid[i]),
            .worse_in    (worse_in),
            .hit_in      (hit_in),
            .new_id      (new_id),
            .new_price   (new_price),
            .new_qty     (new_qty),
            .left_id     (id_q[L]),
            .left_price  (price_q[L]),
            .left_qty    (qty_q[L]),
            .right_id    (id_q[R]),
            .right_price (price_q[R]),
            .right_qty   (qty_q[R]),
            .id          (id_q[i]),
            .price       (price_q[i]),
            .qty         (qty_q[i]),
            .worse_out   (worse[i]),
            .hit_out     (hit[i])
        );
    end

    assign stat.hit   = hit[BOOK_DEPTH-1];
    assign stat.full  = (count_reg == CW'(BOOK_DEPTH));
    assign stat.empty = (count_reg == '0);

    assign head_id    = id_q[0];
    assign head_price = price_q[0];
    assign head_qty   = qty_q[0];

    always_comb
    begin
        count_next = count_reg;
        case (op)
            BOOK_INS:
                if (!stat.full)
                    count_next = count_reg + CW'(1);
            BOOK_DEL:
                if (stat.hit)
                    count_next = count_reg - CW'(1);
            BOOK_POP:
                if (!stat.empty)
                    count_next = count_reg - CW'(1);
            default:
                count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BOOK_DEPTH))
        else $error("book count beyond depth");

    a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
        (op == BOOK_INS) |-> !stat.full)
        else $error("insert into full book side");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (op == BOOK_POP || op == BOOK_SETQ) |-> !stat.empty)
        else $error("head change on empty book side");

endmodule

// File: dv/limit_order_book_matcher_unit_tb.sv
// Self-checking testbench of the limit order book matcher with a predicting scoreboard.
module limit_order_book_matcher_unit_tb;
    import lobm_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [1:0] MODE_CANCEL = 2'd2;
    localparam logic [1:0] MODE_CANCEL_ALT = 2'd3;

    typedef struct {
        logic [31:0] id;
        logic [15:0] price;
        logic [15:0] qty;
    } resting_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] buyer;
        logic [31:0] seller;
        logic [15:0] qty;
        logic [15:0] price;
        logic        last;
    } record_t;

    class book_scoreboard;
        resting_t bids[$];
        resting_t asks[$];
        record_t  pending[$];
        int       errors;
        int       checked;

        function void push_rec(kind_t k, logic [31:0] b, logic [31:0] s,
                               logic [15:0] q, logic [15:0] p, logic l);
            record_t r;
            r.kind = k; r.buyer = b; r.seller = s; r.qty = q; r.price = p; r.last = l;
            pending = {pending, r};
        endfunction

        function bit drop_id(ref resting_t side[$], input logic [31:0] id);
            foreach (side[i])
                if (side[i].id == id)
                begin
                    side.delete(i);
                    return 1;
                end
            return 0;
        endfunction

        function void note_order(logic [1:0] md, logic [31:0] id, logic [15:0] lim,
                                 logic [15:0] qin);
            logic [15:0] left, fill;
            bit buy, found;
            resting_t e;
            int pos;
            if (md >= MODE_CANCEL)
            begin
                found = drop_id(bids, id);
                if (!found) found = drop_id(asks, id);
                push_rec(found ? KIND_CANCELLED : KIND_NOT_FOUND, id, 0, 0, 0, 1);
                return;
            end
            buy = (md == MODE_BUY);
            left = qin;
            if (buy)
                while (left > 0 && asks.size() > 0 && asks[0].price <= lim)
                begin
                    fill = left < asks[0].qty ? left : asks[0].qty;
                    left -= fill; asks[0].qty -= fill;
                    push_rec(KIND_TRADE, id, asks[0].id, fill, asks[0].price, 0);
                    if (asks[0].qty == 0) void'(asks.pop_front());
                end
            else
                while (left > 0 && bids.size() > 0 && bids[0].price >= lim)
                begin
                    fill = left < bids[0].qty ? left : bids[0].qty;
                    left -= fill; bids[0].qty -= fill;
                    push_rec(KIND_TRADE, bids[0].id, id, fill, bids[0].price, 0);
                    if (bids[0].qty == 0) void'(bids.pop_front());
                end
            if (left == 0)
                push_rec(KIND_FILLED, id, 0, 0, 0, 1);
            else if ((buy ? bids.size() : asks.size()) >= DEPTH)
                push_rec(KIND_REJECTED, id, 0, left, 0, 1);
            else
            begin
                e.id = id; e.price = lim; e.qty = left;
                if (buy)
                begin
                    pos = 0;
                    while (pos < bids.size() && bids[pos].price >= lim) pos++;
                    bids.insert(pos, e);
                end
                else
                begin
                    pos = 0;
                    while (pos < asks.size() && asks[pos].price <= lim) pos++;
                    asks.insert(pos, e);
                end
                push_rec(KIND_RESTED, id, 0, left, 0, 1);
            end
        endfunction

        function void check_record(logic [2:0] k, logic [31:0] b, logic [31:0] s,
                                   logic [15:0] q, logic [15:0] p, logic l);
            record_t x;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected record kind=%0d buyer=%h", $time, k, b);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (k !== x.kind)
            begin
                $display("%0t: kind exp %0d got %0d", $time, x.kind, k); errors++;
            end
            if (b !== x.buyer)
            begin
                $display("%0t: buyer_id exp %h got %h", $time, x.buyer, b); errors++;
            end
            if (s !== x.seller)
            begin
                $display("%0t: seller_id exp %h got %h", $time, x.seller, s); errors++;
            end
            if (q !== x.qty)
            begin
                $display("%0t: trade_qty exp %0d got %0d", $time, x.qty, q); errors++;
            end
            if (p !== x.price)
            begin
                $display("%0t: trade_price exp %0d got %0d", $time, x.price, p); errors++;
            end
            if (l !== x.last)
            begin
                $display("%0t: last exp %0d got %0d", $time, x.last, l); errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [1:0]  mode;
    logic [31:0] order_id, buyer_id, seller_id;
    logic [15:0] limit_price, quantity, trade_qty, trade_price;
    logic [2:0]  kind;
    logic        last;

    book_scoreboard sb;
    bit quiet_phase;
    bit hold_off;
    int sent;
    logic [31:0] id_pool[$];

    limit_order_book_matcher_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .order_id(order_id), .limit_price(limit_price), .quantity(quantity),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .buyer_id(buyer_id), .seller_id(seller_id),
        .trade_qty(trade_qty), .trade_price(trade_price), .last(last)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("limit_order_book_matcher_unit_tb: FAIL");
        $finish;
    end

    // Offer one transaction, with an optional random gap first; hold until accepted.
    task automatic send_order(logic [1:0] md, logic [31:0] id, logic [15:0] lim,
                              logic [15:0] q);
        while (!quiet_phase && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1; mode <= md; order_id <= id; limit_price <= lim; quantity <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_order(md, id, lim, q);
        if (md < MODE_CANCEL) id_pool = {id_pool, id};
        sent++;
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random order: prices in a narrow band so that crosses are common.
    task automatic random_order();
        logic [1:0] md;
        logic [31:0] id;
        logic [15:0] lim, q;
        int r;
        r = $urandom_range(99);
        md = (r < 42) ? MODE_BUY : (r < 84) ? MODE_SELL :
             (r < 96) ? MODE_CANCEL : MODE_CANCEL_ALT;
        if (md >= MODE_CANCEL && id_pool.size() > 0 && $urandom_range(3) != 0)
            id = id_pool[$urandom_range(id_pool.size() - 1)];
        else if ($urandom_range(9) == 0)
            id = $urandom;
        else
            id = $urandom_range(63);
        r = $urandom_range(19);
        lim = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 :
              (r == 2) ? 16'($urandom) : 16'd1000 + 16'($urandom_range(15));
        r = $urandom_range(19);
        q = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
            (r == 2) ? 16'($urandom) : 16'($urandom_range(1, 40));
        send_order(md, id, lim, q);
    endtask

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_record(kind, buyer_id, seller_id, trade_qty, trade_price, last);

    always @(posedge clk or negedge rst_n)
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || (!quiet_phase && $urandom_range(99) < 17);

    initial
    begin
        int i, waited;
        sb = new();
        rst_n = 0; in_valid = 0; mode = 0; order_id = 0; limit_price = 0; quantity = 0;
        quiet_phase = 0; hold_off = 0; sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty book, extremes, cancels, duplicate ids, sweep of the book.
        send_order(MODE_CANCEL, 32'd5, 0, 0);
        send_order(MODE_BUY, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_order(MODE_BUY, 32'd1, 16'd100, 16'hFFFF);
        send_order(MODE_BUY, 32'd2, 16'd100, 16'd10);
        send_order(MODE_BUY, 32'd2, 16'd90, 16'd7);
        send_order(MODE_SELL, 32'd3, 16'd0, 16'd5);
        send_order(MODE_SELL, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_order(MODE_CANCEL_ALT, 32'd2, 16'hFFFF, 16'hFFFF);
        send_order(MODE_CANCEL, 32'hFFFF_FFFF, 0, 0);
        send_order(MODE_CANCEL, 32'hFFFF_FFFF, 0, 0);
        send_order(MODE_SELL, 32'd4, 16'd50, 16'hFFFF);
        send_order(MODE_CANCEL, 32'd4, 0, 0);

        // Fill the ask side to the brim, then reject, then sweep it in one order.
        quiet_phase = 1;
        for (i = 0; i < DEPTH; i++)
            send_order(MODE_SELL, 32'd200 + i, 16'd2000 + i[3:0], 16'd1);
        send_order(MODE_SELL, 32'hA5A5_5A5A, 16'd3000, 16'd9);
        // Receiver holds off while the sender keeps offering, so the input stalls.
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            begin
                send_order(MODE_BUY, 32'h5A5A_A5A5, 16'hFFFF, 16'hFFFF);
                send_order(MODE_BUY, 32'd7, 16'd10, 16'd3);
                send_order(MODE_CANCEL, 32'd7, 0, 0);
            end
        join
        quiet_phase = 0;

        for (i = 0; i < 172; i++)
        begin
            quiet_phase = (i >= 80 && i < 120);
            random_order();
        end
        quiet_phase = 0;
        idle_input();

        waited = 0;
        while (sb.pending.size() > 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        $display("Covered %0d orders and cancels, %0d records checked, full-book reject",
                 sent, sb.checked);
        $display("and a full-side sweep under a long output hold-off.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("limit_order_book_matcher_unit_tb: PASS");
        else
            $display("limit_order_book_matcher_unit_tb: FAIL");
        $finish;
    end
endmodule
